@@ design/htwd_pkg.sv @@
// Package for the Huffman tree-walk decoder: sizes, field widths, node layout,
// command codes, controller states and the controller/datapath link structs.
// No dependencies.
`default_nettype none
package htwd_pkg;

	localparam int NODE_COUNT  = 512;
	localparam int SYMBOL_BITS = 8;
	localparam int NODE_AW     = $clog2(NODE_COUNT);

	localparam int CMD_W   = 2;
	localparam int IDX_W   = 9;
	localparam int SYM_W   = 8;
	localparam int BYTE_W  = 8;
	localparam int CNT_W   = 4;
	localparam int BYTE_BITS = 8;
	localparam int TOP_BIT   = 7;

	localparam logic [SYM_W-1:0] SYM_MASK = SYM_W'((64'd1 << SYMBOL_BITS) - 64'd1);

	typedef struct packed {
		logic             leaf;
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic [SYM_W-1:0] sym;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE  = 2'd0,
		CMD_START  = 2'd1,
		CMD_DECODE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_TEST,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic wr_node;
		logic set_root;
		logic ld_item;
		logic rd_cur;
		logic step;
		logic leaf_take;
		logic rd_root;
		logic flush_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_leaf;
		logic bits_zero;
		logic pend_valid;
		logic out_free;
	} dp_stat_t;

	function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
		return 32'(idx) < NODE_COUNT;
	endfunction

endpackage
`default_nettype wire

@@ design/htwd_if.sv @@
// Stream interfaces of the decoder: command items in, decoded symbols out.
// Depends on htwd_pkg.
`default_nettype none
interface htwd_item_if;
	logic                       valid;
	logic                       ready;
	logic [htwd_pkg::CMD_W-1:0]  command;
	logic [htwd_pkg::IDX_W-1:0]  node_index;
	logic                       node_is_leaf;
	logic [htwd_pkg::IDX_W-1:0]  left_child;
	logic [htwd_pkg::IDX_W-1:0]  right_child;
	logic [htwd_pkg::SYM_W-1:0]  leaf_symbol;
	logic [htwd_pkg::BYTE_W-1:0] data_byte;
	logic [htwd_pkg::CNT_W-1:0]  bit_count;

	modport source (output valid, command, node_index, node_is_leaf, left_child,
		right_child, leaf_symbol, data_byte, bit_count, input ready);
	modport sink (input valid, command, node_index, node_is_leaf, left_child,
		right_child, leaf_symbol, data_byte, bit_count, output ready);
endinterface

interface htwd_result_if;
	logic                      valid;
	logic                      ready;
	logic [htwd_pkg::SYM_W-1:0] symbol;
	logic                      last;

	modport source (output valid, symbol, last, input ready);
	modport sink (input valid, symbol, last, output ready);
endinterface
`default_nettype wire

@@ design/huffman_tree_walk_decoder.sv @@
// Huffman tree-walk decoder, top level: controller plus datapath.
// Write-node and start transactions are both accepted in the idle state.
// Decode: an accept step, a walk-start step, one step per bit, a root re-read for each symbol
// reached before the last bit, and a flush step; a busy output register stalls the walk.
// Reset clears the root register, current node and all handshake state; the node
// table has no reset and holds garbage until written.
`default_nettype none
module huffman_tree_walk_decoder (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [htwd_pkg::IDX_W-1:0] cfg_wr_data,
	htwd_item_if.sink                       item,
	htwd_result_if.source                   result
);
	import htwd_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	logic      item_ready;

	assign item.ready = item_ready;

	htwd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item.valid),
		.item_cmd  (item.command),
		.item_ready(item_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	htwd_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item       (item),
		.result     (result),
		.cmd        (cmd),
		.stat       (stat)
	);
endmodule
`default_nettype wire

@@ design/htwd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module htwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

@@ design/htwd_ctrl.sv @@
// Controller of the decoder: sequences table writes, root starts and the
// bit-by-bit walk. Depends on htwd_pkg.
`default_nettype none
module htwd_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      item_valid,
	input  wire logic [htwd_pkg::CMD_W-1:0] item_cmd,
	output logic                           item_ready,
	input  wire htwd_pkg::dp_stat_t        stat,
	output htwd_pkg::ctrl_cmd_t            cmd
);
	import htwd_pkg::*;

	state_t state_q, state_d;
	logic   stall;

	assign stall = stat.pend_valid && !stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid && cmd_t'(item_cmd) == CMD_DECODE) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				state_d = stat.bits_zero ? ST_FLUSH : ST_TEST;
			end
			ST_TEST: begin
				if (stat.is_leaf) begin
					if (!stall) begin
						state_d = stat.bits_zero ? ST_FLUSH : ST_WALK;
					end
				end else if (stat.bits_zero) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!stat.pend_valid || stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					case (cmd_t'(item_cmd))
						CMD_WRITE:  cmd.wr_node  = 1'b1;
						CMD_START:  cmd.set_root = 1'b1;
						CMD_DECODE: begin
							cmd.ld_item = 1'b1;
							cmd.rd_cur  = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ST_WALK: begin
				cmd.step = !stat.bits_zero;
			end
			ST_TEST: begin
				if (stat.is_leaf) begin
					if (!stall) begin
						cmd.leaf_take = 1'b1;
						cmd.rd_root   = !stat.bits_zero;
					end
				end else begin
					cmd.step = !stat.bits_zero;
				end
			end
			ST_FLUSH: begin
				cmd.flush_out = stat.pend_valid && stat.out_free;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ design/htwd_dpath.sv @@
// Datapath of the decoder: node table, current node, bit shifter, pending
// symbol and output register. Depends on htwd_pkg, htwd_if, htwd_ram.
`default_nettype none
module htwd_dpath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [htwd_pkg::IDX_W-1:0] cfg_wr_data,
	htwd_item_if.sink                       item,
	htwd_result_if.source                   result,
	input  wire htwd_pkg::ctrl_cmd_t        cmd,
	output htwd_pkg::dp_stat_t              stat
);
	import htwd_pkg::*;

	logic [IDX_W-1:0]  root_q;
	logic [IDX_W-1:0]  cur_q;
	logic [BYTE_W-1:0] byte_q;
	logic [CNT_W-1:0]  count_q;
	logic              rd_oor_q;
	logic              pend_valid_q;
	logic [SYM_W-1:0]  pend_sym_q;
	logic              out_valid_q;
	logic [SYM_W-1:0]  out_sym_q;
	logic              out_last_q;

	logic [NODE_W-1:0] rd_data;
	node_t             here;
	logic [IDX_W-1:0]  child;
	logic [IDX_W-1:0]  rd_idx;
	logic              rd_en;
	logic              wr_en;
	node_t             wr_node;
	logic              out_free;
	logic              push_out;

	assign here  = rd_oor_q ? node_t'('0) : node_t'(rd_data);
	assign child = byte_q[TOP_BIT] ? here.right : here.left;

	assign rd_en  = cmd.rd_cur || cmd.step || cmd.rd_root;
	assign rd_idx = cmd.step ? child : (cmd.rd_root ? root_q : cur_q);

	assign wr_en   = cmd.wr_node && idx_in_range(item.node_index);
	assign wr_node = '{leaf: item.node_is_leaf, left: item.left_child,
		right: item.right_child, sym: item.leaf_symbol & SYM_MASK};

	htwd_ram #(
		.WIDTH(NODE_W),
		.DEPTH(NODE_COUNT)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(NODE_AW'(item.node_index)),
		.wr_data(wr_node),
		.rd_en  (rd_en),
		.rd_addr(NODE_AW'(rd_idx)),
		.rd_data(rd_data)
	);

	assign out_free = !out_valid_q || result.ready;
	assign push_out = cmd.flush_out || (cmd.leaf_take && pend_valid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q       <= '0;
			cur_q        <= '0;
			count_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				root_q <= cfg_wr_data;
			end
			if (cmd.set_root || cmd.leaf_take) begin
				cur_q <= root_q;
			end else if (cmd.step) begin
				cur_q <= child;
			end
			if (cmd.ld_item) begin
				count_q <= (item.bit_count > CNT_W'(BYTE_BITS)) ? CNT_W'(BYTE_BITS)
					: item.bit_count;
			end else if (cmd.step) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.leaf_take) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush_out) begin
				pend_valid_q <= 1'b0;
			end
			if (push_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			byte_q <= item.data_byte;
		end else if (cmd.step) begin
			byte_q <= {byte_q[BYTE_W-2:0], 1'b0};
		end
		if (rd_en) begin
			rd_oor_q <= !idx_in_range(rd_idx);
		end
		if (cmd.leaf_take) begin
			pend_sym_q <= here.sym;
		end
		if (push_out) begin
			out_sym_q  <= pend_sym_q;
			out_last_q <= cmd.flush_out;
		end
	end

	assign result.valid  = out_valid_q;
	assign result.symbol = out_sym_q;
	assign result.last   = out_last_q;

	assign stat.is_leaf    = here.leaf;
	assign stat.bits_zero  = (count_q == '0);
	assign stat.pend_valid = pend_valid_q;
	assign stat.out_free   = out_free;
endmodule
`default_nettype wire
